FILE: rtl/core/sacl_pkg.sv
package sacl_pkg;

   localparam int ADDR_W  = 64;
   localparam int TAG_W   = 64;
   localparam int STAMP_W = 64;
   localparam int CNT_W   = 32;

   // One way of a set: valid flag, tag and recency stamp.
   typedef struct packed {
      logic               valid;
      logic [TAG_W-1:0]   tag;
      logic [STAMP_W-1:0] stamp;
   } way_type;

   localparam int WAY_W = $bits(way_type);

   typedef enum logic [1:0] {
      OUT_HIT   = 2'd0,
      OUT_MISS  = 2'd1,
      OUT_EVICT = 2'd2
   } outcome_type;

   localparam logic [1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [1:0] CSR_WAYS       = 2'd2;

endpackage

FILE: rtl/core/sacl_ram.sv
module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    we_i,
   input  logic                                    re_i,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
   input  logic [WIDTH-1:0]                        wdata_i,
   output logic [WIDTH-1:0]                        rdata_o
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we_i) begin
         mem[addr_i] <= wdata_i;
      end
      if (re_i) begin
         rdata_o <= mem[addr_i];
      end
   end

endmodule

FILE: rtl/core/sacl_split.sv
module sacl_split #(
   parameter int SET_W = 10
) (
   input  logic [sacl_pkg::ADDR_W-1:0] address_i,
   input  logic [5:0]                  block_bits_i,
   input  logic [$clog2(SET_W+1)-1:0]  set_bits_i,
   output logic [SET_W-1:0]            set_idx_o,
   output logic [sacl_pkg::TAG_W-1:0]  tag_o
);

   logic [sacl_pkg::ADDR_W-1:0] shifted;
   logic [SET_W-1:0]            mask;
   logic [6:0]                  tag_amt;

   always_comb begin
      shifted   = address_i >> block_bits_i;
      mask      = ~({SET_W{1'b1}} << set_bits_i);
      set_idx_o = shifted[SET_W-1:0] & mask;
      tag_amt   = {1'b0, block_bits_i} + 7'(set_bits_i);
      // shift of 64 or more drops every bit
      if (tag_amt[6]) begin
         tag_o = '0;
      end else begin
         tag_o = address_i >> tag_amt[5:0];
      end
   end

endmodule

FILE: rtl/core/sacl_lookup.sv
module sacl_lookup #(
   parameter int MAX_WAYS = 8
) (
   input  sacl_pkg::way_type [MAX_WAYS-1:0]              row_i,
   input  logic [sacl_pkg::TAG_W-1:0]                    tag_i,
   input  logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] last_way_i,
   output logic                                          hit_o,
   output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] hit_way_o,
   output logic                                          free_o,
   output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] free_way_o
);

   localparam int WAY_IDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

   // Walk from the top way down so the lowest matching way wins.
   always_comb begin
      hit_o      = 1'b0;
      hit_way_o  = '0;
      free_o     = 1'b0;
      free_way_o = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (WAY_IDX_W'(w) <= last_way_i) begin
            if (row_i[w].valid && (row_i[w].tag == tag_i)) begin
               hit_o     = 1'b1;
               hit_way_o = WAY_IDX_W'(w);
            end
            if (!row_i[w].valid) begin
               free_o     = 1'b1;
               free_way_o = WAY_IDX_W'(w);
            end
         end
      end
   end

endmodule

FILE: rtl/core/set_assoc_cache_lru_sim.sv
// Tag-only set-associative cache with least-recently-used replacement.
// Request channel: drive req_address and req_command with start; the request
// is taken on a rising edge where start is high and busy is low. A load or
// store (command 0) makes one access, a modify (command 1) makes two.
// Response channel: each access gives one response, shown for one cycle with
// rsp_valid high: outcome, saturating hit/miss/eviction totals after this
// access, and rsp_last on the final response of the request. The receiver
// cannot stall; it must take each response in its strobe cycle.
// Access steps: a hit or a fill into a free way reads the set row, then
// compares and writes back, and the response is registered from that compare.
// A miss that evicts scans the set for the oldest line one way per cycle
// before it writes back. A modify adds a second read-compare-write pass.
// The block takes no new request until the last access of the previous one
// has written back; a new request may be taken while a response shows.
// Reset: a clearing pass writes every set row invalid, one row per cycle,
// over all 2**MAX_SET_BITS rows (1024 by default) with busy high. Configuration
// writes (csr_we, csr_index, csr_wdata) are taken at any time but belong to
// idle periods; they do not clear the store.
module set_assoc_cache_lru_sim #(
   parameter int MAX_SET_BITS = 10,
   parameter int MAX_WAYS     = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [sacl_pkg::ADDR_W-1:0]   req_address,
   input  logic                          req_command,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_outcome,
   output logic [sacl_pkg::CNT_W-1:0]    rsp_hit_total,
   output logic [sacl_pkg::CNT_W-1:0]    rsp_miss_total,
   output logic [sacl_pkg::CNT_W-1:0]    rsp_eviction_total,
   output logic                          rsp_last,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [5:0]                    csr_wdata
);

   localparam int SB_W      = $clog2(MAX_SET_BITS + 1);
   localparam int WAY_IDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int DEPTH     = 1 << MAX_SET_BITS;
   localparam int ROW_W     = MAX_WAYS * sacl_pkg::WAY_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOOK,
      ST_SCAN
   } state_type;

   // control state
   state_type                      state_ff, state_in;
   logic [MAX_SET_BITS-1:0]        clr_ff, clr_in;
   logic                           second_ff, second_in;
   logic [sacl_pkg::STAMP_W-1:0]   clk_ff, clk_in;
   logic [sacl_pkg::CNT_W-1:0]     hits_ff, hits_in;
   logic [sacl_pkg::CNT_W-1:0]     misses_ff, misses_in;
   logic [sacl_pkg::CNT_W-1:0]     evictions_ff, evictions_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   sacl_pkg::outcome_type          outcome_ff, outcome_in;
   logic                           last_ff, last_in;
   logic [3:0]                     csr_set_bits_ff;
   logic [5:0]                     csr_block_bits_ff;
   logic [3:0]                     csr_ways_ff;

   // per-access payload
   logic [MAX_SET_BITS-1:0]        set_ff, set_in;
   logic [sacl_pkg::TAG_W-1:0]     tag_ff, tag_in;
   logic [WAY_IDX_W-1:0]           scan_ff, scan_in;
   logic [WAY_IDX_W-1:0]           best_ff, best_in;
   logic [sacl_pkg::STAMP_W-1:0]   best_age_ff, best_age_in;

   // effective configuration
   logic [SB_W-1:0]                sb;
   logic [WAY_IDX_W-1:0]           last_way;

   logic [MAX_SET_BITS-1:0]        split_set;
   logic [sacl_pkg::TAG_W-1:0]     split_tag;

   logic                           ram_we;
   logic                           ram_re;
   logic [MAX_SET_BITS-1:0]        ram_addr;
   sacl_pkg::way_type [MAX_WAYS-1:0] row_rdata;
   sacl_pkg::way_type [MAX_WAYS-1:0] row_wdata;

   logic                           hit;
   logic [WAY_IDX_W-1:0]           hit_way;
   logic                           free;
   logic [WAY_IDX_W-1:0]           free_way;

   logic                           fin;
   logic [WAY_IDX_W-1:0]           fin_way;
   sacl_pkg::outcome_type          fin_outcome;
   logic [sacl_pkg::STAMP_W-1:0]   scan_age;
   logic                           scan_better;
   logic [WAY_IDX_W-1:0]           best_next;

   // Clamp set bits and way count to what the store holds; zero ways counts as one.
   always_comb begin
      if (csr_set_bits_ff > MAX_SET_BITS) begin
         sb = SB_W'(MAX_SET_BITS);
      end else begin
         sb = SB_W'(csr_set_bits_ff);
      end
      if (csr_ways_ff == 4'd0) begin
         last_way = '0;
      end else if (csr_ways_ff > MAX_WAYS) begin
         last_way = WAY_IDX_W'(MAX_WAYS - 1);
      end else begin
         last_way = WAY_IDX_W'(csr_ways_ff - 4'd1);
      end
   end

   sacl_split #(
      .SET_W (MAX_SET_BITS)
   ) u_split (
      .address_i    (req_address),
      .block_bits_i (csr_block_bits_ff),
      .set_bits_i   (sb),
      .set_idx_o    (split_set),
      .tag_o        (split_tag)
   );

   // One row per set holds all ways; read data holds until the next read.
   sacl_ram #(
      .WIDTH (ROW_W),
      .DEPTH (DEPTH)
   ) u_set_ram (
      .clock   (clock),
      .we_i    (ram_we),
      .re_i    (ram_re),
      .addr_i  (ram_addr),
      .wdata_i (row_wdata),
      .rdata_o (row_rdata)
   );

   sacl_lookup #(
      .MAX_WAYS (MAX_WAYS)
   ) u_lookup (
      .row_i      (row_rdata),
      .tag_i      (tag_ff),
      .last_way_i (last_way),
      .hit_o      (hit),
      .hit_way_o  (hit_way),
      .free_o     (free),
      .free_way_o (free_way)
   );

   // Victim scan: age is clock minus stamp, modulo 2**64; keep the first
   // way on ties.
   always_comb begin
      scan_age    = clk_ff - row_rdata[scan_ff].stamp;
      scan_better = scan_age > best_age_ff;
      best_next   = scan_better ? scan_ff : best_ff;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      second_in    = second_ff;
      clk_in       = clk_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      evictions_in = evictions_ff;
      rsp_valid_in = 1'b0;
      outcome_in   = outcome_ff;
      last_in      = last_ff;
      set_in       = set_ff;
      tag_in       = tag_ff;
      scan_in      = scan_ff;
      best_in      = best_ff;
      best_age_in  = best_age_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_addr     = set_ff;
      row_wdata    = '0;
      fin          = 1'b0;
      fin_way      = '0;
      fin_outcome  = sacl_pkg::OUT_HIT;

      case (state_ff)
         ST_CLEAR: begin
            // write one invalid row per cycle
            ram_we   = 1'b1;
            ram_addr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               ram_re    = 1'b1;
               ram_addr  = split_set;
               set_in    = split_set;
               tag_in    = split_tag;
               second_in = req_command;
               clk_in    = clk_ff + 1'b1;
               state_in  = ST_LOOK;
            end
         end
         ST_READ: begin
            // second access of a modify: reread the row just written
            ram_re   = 1'b1;
            clk_in   = clk_ff + 1'b1;
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (hit) begin
               fin     = 1'b1;
               fin_way = hit_way;
            end else if (free) begin
               fin         = 1'b1;
               fin_way     = free_way;
               fin_outcome = sacl_pkg::OUT_MISS;
            end else if (last_way == '0) begin
               fin         = 1'b1;
               fin_outcome = sacl_pkg::OUT_EVICT;
            end else begin
               best_in     = '0;
               best_age_in = clk_ff - row_rdata[0].stamp;
               scan_in     = WAY_IDX_W'(1);
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff == last_way) begin
               fin         = 1'b1;
               fin_way     = best_next;
               fin_outcome = sacl_pkg::OUT_EVICT;
            end else begin
               best_in     = best_next;
               best_age_in = scan_better ? scan_age : best_age_ff;
               scan_in     = scan_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (fin) begin
         // write back the row with the touched way refreshed
         ram_we             = 1'b1;
         row_wdata          = row_rdata;
         row_wdata[fin_way] = '{valid: 1'b1, tag: tag_ff, stamp: clk_ff};
         rsp_valid_in       = 1'b1;
         outcome_in         = fin_outcome;
         last_in            = !second_ff;
         second_in          = 1'b0;
         state_in           = second_ff ? ST_READ : ST_IDLE;
         if (fin_outcome == sacl_pkg::OUT_HIT) begin
            hits_in = (hits_ff == '1) ? hits_ff : hits_ff + 1'b1;
         end else begin
            misses_in = (misses_ff == '1) ? misses_ff : misses_ff + 1'b1;
         end
         if (fin_outcome == sacl_pkg::OUT_EVICT) begin
            evictions_in = (evictions_ff == '1) ? evictions_ff : evictions_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_CLEAR;
         clr_ff            <= '0;
         second_ff         <= 1'b0;
         clk_ff            <= sacl_pkg::STAMP_W'(1);
         hits_ff           <= '0;
         misses_ff         <= '0;
         evictions_ff      <= '0;
         rsp_valid_ff      <= 1'b0;
         outcome_ff        <= sacl_pkg::OUT_HIT;
         last_ff           <= 1'b0;
         csr_set_bits_ff   <= 4'd4;
         csr_block_bits_ff <= 6'd4;
         csr_ways_ff       <= 4'd1;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         second_ff    <= second_in;
         clk_ff       <= clk_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         evictions_ff <= evictions_in;
         rsp_valid_ff <= rsp_valid_in;
         outcome_ff   <= outcome_in;
         last_ff      <= last_in;
         if (csr_we) begin
            case (csr_index)
               sacl_pkg::CSR_SET_BITS:   csr_set_bits_ff   <= csr_wdata[3:0];
               sacl_pkg::CSR_BLOCK_BITS: csr_block_bits_ff <= csr_wdata;
               sacl_pkg::CSR_WAYS:       csr_ways_ff       <= csr_wdata[3:0];
               default: begin
                  // drop writes to unknown indexes
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      set_ff      <= set_in;
      tag_ff      <= tag_in;
      scan_ff     <= scan_in;
      best_ff     <= best_in;
      best_age_ff <= best_age_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_outcome        = outcome_ff;
   assign rsp_hit_total      = hits_ff;
   assign rsp_miss_total     = misses_ff;
   assign rsp_eviction_total = evictions_ff;
   assign rsp_last           = last_ff;

   // A response follows only a compare or a scan step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_LOOK || $past(state_ff) == ST_SCAN))
      else $error("response without a finished access");

   // The first response of a modify is followed by the second pass.
   a_modify_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !last_ff) |-> (state_ff == ST_READ && !second_ff))
      else $error("modify lost its second access");

   // Every eviction is also a miss.
   a_evict_le_miss: assert property (@(posedge clock) disable iff (reset)
      evictions_ff <= misses_ff)
      else $error("eviction total above miss total");

   // Hit and miss totals never go back.
   a_hits_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (hits_ff >= $past(hits_ff) && misses_ff >= $past(misses_ff)))
      else $error("hit or miss total decreased");

endmodule

FILE: bench/set_assoc_cache_lru_sim_tb.sv
module set_assoc_cache_lru_sim_tb;

   localparam int MAX_SET_BITS = 10;
   localparam int MAX_WAYS     = 8;
   localparam int LINES        = (1 << MAX_SET_BITS) * MAX_WAYS;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS  = 132;
   localparam int PRINT_LIMIT  = 60;

   // Index past the three registers; the block must ignore writes to it.
   localparam logic [1:0] CSR_SPARE = 2'd3;

   // Register settings for the random phases, raw write data {set_bits, block_bits, ways}.
   // Some carry bits above the register width, or values past the clamps.
   localparam int FIXED_PHASES = 12;
   localparam logic [17:0] PHASE_CFG [FIXED_PHASES] = '{
      {6'd4,  6'd4,  6'd1},
      {6'd0,  6'd0,  6'd1},
      {6'd10, 6'd32, 6'd8},
      {6'h1F, 6'd63, 6'h3F},
      {6'd2,  6'd6,  6'd0},
      {6'd10, 6'd0,  6'd8},
      {6'd3,  6'd5,  6'd4},
      {6'd1,  6'd2,  6'd2},
      {6'h2C, 6'd60, 6'd9},
      {6'd5,  6'd31, 6'd3},
      {6'd0,  6'd63, 6'h38},
      {6'd8,  6'd16, 6'd6}
   };
   localparam int RANDOM_PHASES = 2;

   typedef struct packed {
      logic [sacl_pkg::ADDR_W-1:0] address;
      logic                        command;
   } request_type;

   typedef struct packed {
      sacl_pkg::outcome_type       outcome;
      logic [sacl_pkg::CNT_W-1:0]  hits;
      logic [sacl_pkg::CNT_W-1:0]  misses;
      logic [sacl_pkg::CNT_W-1:0]  evictions;
      logic                        last;
   } access_result_type;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          start       = 1'b0;
   logic [sacl_pkg::ADDR_W-1:0]   req_address = '0;
   logic                          req_command = 1'b0;
   logic                          csr_we      = 1'b0;
   logic [1:0]                    csr_index   = sacl_pkg::CSR_SET_BITS;
   logic [5:0]                    csr_wdata   = '0;
   logic                          busy;
   logic                          rsp_valid;
   logic [1:0]                    rsp_outcome;
   logic [sacl_pkg::CNT_W-1:0]    rsp_hit_total;
   logic [sacl_pkg::CNT_W-1:0]    rsp_miss_total;
   logic [sacl_pkg::CNT_W-1:0]    rsp_eviction_total;
   logic                          rsp_last;

   set_assoc_cache_lru_sim #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_address        (req_address),
      .req_command        (req_command),
      .rsp_valid          (rsp_valid),
      .rsp_outcome        (rsp_outcome),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total),
      .rsp_last           (rsp_last),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #1 clock = ~clock;

   // Shadow copy of the tag store, recency clock, totals and registers.
   bit                           line_valid [LINES];
   bit [sacl_pkg::TAG_W-1:0]     line_tag   [LINES];
   bit [sacl_pkg::STAMP_W-1:0]   line_stamp [LINES];
   bit [sacl_pkg::STAMP_W-1:0]   lru_clock      = 1;
   bit [sacl_pkg::CNT_W-1:0]     hit_tally      = 0;
   bit [sacl_pkg::CNT_W-1:0]     miss_tally     = 0;
   bit [sacl_pkg::CNT_W-1:0]     evict_count    = 0;
   bit [3:0]                     cfg_set_bits   = 4;
   bit [5:0]                     cfg_block_bits = 4;
   bit [3:0]                     cfg_ways       = 1;

   request_type        request_queue    [$];
   access_result_type  expected_results [$];

   int unsigned        error_count     = 0;
   int unsigned        requests_taken  = 0;
   int unsigned        responses_seen  = 0;
   int unsigned        settings_used   = 1;
   int unsigned        idle_left       = 0;
   int unsigned        calm_left       = 0;

   function automatic int unsigned eff_set_bits();
      return (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_set_bits;
   endfunction

   function automatic int unsigned eff_ways();
      if (cfg_ways == 0) begin
         return 1;
      end
      return (cfg_ways > MAX_WAYS) ? MAX_WAYS : cfg_ways;
   endfunction

   function automatic bit [sacl_pkg::CNT_W-1:0] bump(input bit [sacl_pkg::CNT_W-1:0] value);
      return (value == '1) ? value : value + 1;
   endfunction

   // One access: split the address, look up the set, refresh, fill or evict.
   function automatic sacl_pkg::outcome_type cache_access(
      input logic [sacl_pkg::ADDR_W-1:0] addr);
      int unsigned                   sb;
      int unsigned                   nw;
      int unsigned                   shift;
      int unsigned                   base;
      int unsigned                   victim;
      int unsigned                   w;
      logic [sacl_pkg::ADDR_W-1:0]   set_idx;
      logic [sacl_pkg::TAG_W-1:0]    tag;
      logic [sacl_pkg::STAMP_W-1:0]  age;
      logic [sacl_pkg::STAMP_W-1:0]  oldest;
      sb = eff_set_bits();
      nw = eff_ways();
      shift = cfg_block_bits + sb;
      set_idx = (addr >> cfg_block_bits) & ((64'd1 << sb) - 64'd1);
      tag = (shift >= sacl_pkg::ADDR_W) ? '0 : addr >> shift;
      base = 32'(set_idx) * MAX_WAYS;
      lru_clock = lru_clock + 1;
      for (w = 0; w < nw; w++) begin
         if (line_valid[base + w] && line_tag[base + w] == tag) begin
            line_stamp[base + w] = lru_clock;
            hit_tally = bump(hit_tally);
            return sacl_pkg::OUT_HIT;
         end
      end
      miss_tally = bump(miss_tally);
      for (w = 0; w < nw; w++) begin
         if (!line_valid[base + w]) begin
            line_valid[base + w] = 1'b1;
            line_tag[base + w] = tag;
            line_stamp[base + w] = lru_clock;
            return sacl_pkg::OUT_MISS;
         end
      end
      // Every way is full: evict the oldest, the lowest way on a tie.
      victim = 0;
      oldest = lru_clock - line_stamp[base];
      for (w = 1; w < nw; w++) begin
         age = lru_clock - line_stamp[base + w];
         if (age > oldest) begin
            oldest = age;
            victim = w;
         end
      end
      evict_count = bump(evict_count);
      line_tag[base + victim] = tag;
      line_stamp[base + victim] = lru_clock;
      return sacl_pkg::OUT_EVICT;
   endfunction

   // Queue the responses one accepted request will produce.
   function automatic void predict_request(input request_type req);
      int unsigned        count;
      int unsigned        k;
      access_result_type  res;
      count = req.command ? 2 : 1;
      for (k = 0; k < count; k++) begin
         res.outcome = cache_access(req.address);
         res.hits = hit_tally;
         res.misses = miss_tally;
         res.evictions = evict_count;
         res.last = (k == count - 1);
         expected_results.push_back(res);
      end
   endfunction

   task automatic flag_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("MISMATCH @%0t: %s", $time, msg);
      end
      error_count++;
   endtask

   // Write one register; mirror it into the shadow copy (block is idle here).
   task automatic csr_write(input logic [1:0] index, input logic [5:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         sacl_pkg::CSR_SET_BITS: begin
            cfg_set_bits = value[3:0];
         end
         sacl_pkg::CSR_BLOCK_BITS: begin
            cfg_block_bits = value;
         end
         sacl_pkg::CSR_WAYS: begin
            cfg_ways = value[3:0];
         end
         default: begin
         end
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Block until every request is taken, every response seen and the block is free.
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (request_queue.size() != 0 || start || expected_results.size() != 0 ||
                 busy !== 1'b0);
   endtask

   // Request driver: present queued requests, idle between them at random.
   always @(posedge clock) begin : drive_requests
      request_type  next_req;
      bit           taken;
      int unsigned  roll;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            predict_request('{req_address, req_command});
            requests_taken++;
            // Pick the gap before the next request: mostly none or short, a few long,
            // and now and then a stretch with no gaps at all.
            if (calm_left > 0) begin
               calm_left--;
               idle_left = 0;
            end else begin
               roll = $urandom_range(99);
               if (roll < 50) begin
                  idle_left = 0;
               end else if (roll < 85) begin
                  idle_left = $urandom_range(1, 3);
               end else if (roll < 97) begin
                  idle_left = $urandom_range(4, 12);
               end else begin
                  idle_left = $urandom_range(20, 60);
               end
               if (roll < 2) begin
                  calm_left = $urandom_range(20, 80);
               end
            end
         end
         if (start && !taken) begin
            // hold the request until the block takes it
         end else if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (request_queue.size() != 0) begin
            next_req = request_queue.pop_front();
            req_address <= next_req.address;
            req_command <= next_req.command;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Response monitor: every strobe must match the oldest expectation.
   always @(posedge clock) begin : check_responses
      access_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         responses_seen++;
         if (expected_results.size() == 0) begin
            flag_mismatch("response with nothing expected");
         end else begin
            want = expected_results.pop_front();
            if (rsp_outcome !== want.outcome)
               flag_mismatch($sformatf("outcome %0d, expected %0d", rsp_outcome, want.outcome));
            if (rsp_hit_total !== want.hits)
               flag_mismatch($sformatf("hit_total %0d, expected %0d", rsp_hit_total, want.hits));
            if (rsp_miss_total !== want.misses)
               flag_mismatch($sformatf("miss_total %0d, expected %0d",
                                       rsp_miss_total, want.misses));
            if (rsp_eviction_total !== want.evictions)
               flag_mismatch($sformatf("eviction_total %0d, expected %0d",
                                       rsp_eviction_total, want.evictions));
            if (rsp_last !== want.last)
               flag_mismatch($sformatf("last %0b, expected %0b", rsp_last, want.last));
         end
      end
   end

   initial begin : run_phases
      logic [sacl_pkg::ADDR_W-1:0]  addr;
      logic [sacl_pkg::ADDR_W-1:0]  tag;
      logic [sacl_pkg::ADDR_W-1:0]  set_sel;
      logic [sacl_pkg::ADDR_W-1:0]  offset_mask;
      logic [sacl_pkg::ADDR_W-1:0]  recent [$];
      logic [17:0]                  setting;
      int unsigned                  sb;
      int unsigned                  nw;
      int unsigned                  roll;
      int unsigned                  phase;
      int unsigned                  n;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset settings, one way per set: fill, hit, modify, eviction and the
      // address extremes.
      @(negedge clock);
      request_queue.push_back('{64'h0, 1'b0});
      request_queue.push_back('{64'h0, 1'b0});
      request_queue.push_back('{64'h0, 1'b1});
      request_queue.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b1});
      request_queue.push_back('{64'h8000_0000_0000_0000, 1'b0});
      request_queue.push_back('{64'h100, 1'b0});
      request_queue.push_back('{64'h0, 1'b1});
      request_queue.push_back('{64'h5555_5555_5555_5555, 1'b0});
      request_queue.push_back('{64'hAAAA_AAAA_AAAA_AAAA, 1'b0});
      request_queue.push_back('{64'hF, 1'b0});
      wait_idle();

      // One set of four ways, no offset: check the replacement order.
      csr_write(sacl_pkg::CSR_SET_BITS, 6'd0);
      csr_write(sacl_pkg::CSR_BLOCK_BITS, 6'd0);
      csr_write(sacl_pkg::CSR_WAYS, 6'd4);
      settings_used++;
      @(negedge clock);
      request_queue.push_back('{64'd10, 1'b0});
      request_queue.push_back('{64'd11, 1'b0});
      request_queue.push_back('{64'd12, 1'b0});
      request_queue.push_back('{64'd13, 1'b0});
      request_queue.push_back('{64'd10, 1'b0});
      request_queue.push_back('{64'd14, 1'b0});
      request_queue.push_back('{64'd11, 1'b1});
      request_queue.push_back('{64'd13, 1'b0});
      request_queue.push_back('{64'd15, 1'b1});
      request_queue.push_back('{64'd12, 1'b0});
      wait_idle();

      // Clamped set bits, zero ways, the widest offset so that the tag shifts out
      // to zero and only the top address bit reaches the set, and a write to the unused index.
      csr_write(sacl_pkg::CSR_SET_BITS, 6'h3F);
      csr_write(sacl_pkg::CSR_BLOCK_BITS, 6'd63);
      csr_write(sacl_pkg::CSR_WAYS, 6'h30);
      csr_write(CSR_SPARE, 6'h2A);
      settings_used++;
      @(negedge clock);
      request_queue.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b0});
      request_queue.push_back('{64'h0, 1'b1});
      request_queue.push_back('{64'h8000_0000_0000_0000, 1'b0});
      request_queue.push_back('{64'h7FFF_FFFF_FFFF_FFFF, 1'b1});
      request_queue.push_back('{64'h8000_0000_0000_0001, 1'b0});
      wait_idle();

      // Random phases: fixed settings first, then a couple drawn at random.
      // Keep the store as it is across settings.
      for (phase = 0; phase < FIXED_PHASES + RANDOM_PHASES; phase++) begin
         if (phase < FIXED_PHASES) begin
            setting = PHASE_CFG[phase];
         end else begin
            setting = 18'($urandom);
         end
         csr_write(sacl_pkg::CSR_WAYS, setting[5:0]);
         csr_write(sacl_pkg::CSR_SET_BITS, setting[17:12]);
         csr_write(sacl_pkg::CSR_BLOCK_BITS, setting[11:6]);
         if ($urandom_range(3) == 0) begin
            csr_write(CSR_SPARE, 6'($urandom));
         end
         settings_used++;
         sb = eff_set_bits();
         nw = eff_ways();
         offset_mask = (64'd1 << cfg_block_bits) - 64'd1;
         @(negedge clock);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(99);
            if (roll < 10 || recent.size() == 0) begin
               addr = {$urandom, $urandom};
            end else if (roll < 45) begin
               // revisit a recent block with a fresh offset
               addr = recent[$urandom_range(recent.size() - 1)];
               addr = (addr & ~offset_mask) | ({$urandom, $urandom} & offset_mask);
            end else begin
               // a few tags over a few sets: enough to fill, hit and evict
               tag = 64'($urandom_range(0, 2 * nw));
               set_sel = 64'($urandom_range(0, (sb < 3) ? (1 << sb) - 1 : 7));
               addr = (tag << (cfg_block_bits + sb)) | (set_sel << cfg_block_bits) |
                      ({$urandom, $urandom} & offset_mask);
            end
            recent.push_back(addr);
            if (recent.size() > 24) begin
               void'(recent.pop_front());
            end
            request_queue.push_back('{addr, $urandom_range(3) == 0});
         end
         wait_idle();
      end

      // Let any stray response show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d requests, %0d responses over %0d register settings.",
               requests_taken, responses_seen, settings_used);
      $display("Cache totals: %0d hits, %0d misses, %0d evictions; %0d mismatches.",
               hit_tally, miss_tally, evict_count, error_count);
      if (error_count == 0) begin
         $display("set_assoc_cache_lru_sim_tb passed");
      end else begin
         $display("set_assoc_cache_lru_sim_tb failed");
      end
      $finish;
   end

   // Drop the run if it hangs: far past the slowest correct run.
   initial begin : watchdog
      #2_000_000;
      $display("set_assoc_cache_lru_sim_tb failed");
      $finish;
   end

endmodule
